// ===== rtl/core/gvcep_pkg.sv =====
package gvcep_pkg;

	// Vertex ids are 20 bits wide; the vertex store spans the whole id space.
	localparam int VADDR_W      = 20;
	localparam int VERTEX_COUNT = 1 << VADDR_W;
	localparam int MAX_PARTS    = 64;
	localparam int PIDX_W       = $clog2(MAX_PARTS);
	localparam int COUNT_WIDTH  = 40;
	localparam int PCOUNT_W     = 7;
	localparam int DEGREE_W     = 24;

	localparam logic [PCOUNT_W-1:0] RESET_PARTS = PCOUNT_W'(4);

	// Placement rules reported with each result
	localparam logic [1:0] RULE_BOTH_NEW = 2'd0;
	localparam logic [1:0] RULE_ONE_NEW  = 2'd1;
	localparam logic [1:0] RULE_OVERLAP  = 2'd2;
	localparam logic [1:0] RULE_FALLBACK = 2'd3;

	typedef logic [MAX_PARTS-1:0]   part_mask_t;
	typedef logic [COUNT_WIDTH-1:0] edge_count_t;

	typedef struct packed {
		logic [VADDR_W-1:0]  src_vertex;
		logic [VADDR_W-1:0]  dst_vertex;
		logic [DEGREE_W-1:0] src_degree;
		logic [DEGREE_W-1:0] dst_degree;
	} edge_req_t;

	typedef struct packed {
		logic [PIDX_W-1:0] chosen_part;
		logic [1:0]        rule_used;
	} place_rsp_t;

	// One node of the least-loaded selection tree
	typedef struct packed {
		logic              ok;
		logic [PIDX_W-1:0] idx;
		edge_count_t       cnt;
	} sel_node_t;

endpackage

// ===== rtl/core/greedy_vertex_cut_edge_placer_core.sv =====
// Greedy vertex-cut edge placer. Each request is one edge with the degrees of
// both endpoints; the block answers with the partition the edge goes to and
// the rule that chose the candidate set. Per-vertex partition masks live in a
// 1,048,576 x 64-bit synchronous memory with two read ports and one write
// port; per-partition edge counts sit in 64 registers that feed a three-stage
// registered selection tree. After reset the block sweeps the vertex memory
// once, one entry a cycle, and in_ready stays low until the sweep ends; the
// part_count register can be written during that sweep. The memory read
// happens at the accepting edge itself; the request then passes through rule
// selection, three tree stages and two mask write-backs through the single
// write port before the result register is loaded. The next request is taken
// in the cycle after the result has been loaded, even if it has not yet been
// collected, so a new edge is accepted only once the previous one has been
// loaded; a result still waiting when the next edge reaches its last
// write-back holds the block there until it is collected. part_count must
// only be written while no edge is in flight.
module greedy_vertex_cut_edge_placer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gvcep_pkg::PCOUNT_W-1:0]  cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  gvcep_pkg::edge_req_t            in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output gvcep_pkg::place_rsp_t           out_place
);
	import gvcep_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RULE,
		ST_T1,
		ST_T2,
		ST_T3,
		ST_WU,
		ST_WV
	} state_t;

	state_t              state_q;
	logic [VADDR_W-1:0]  clr_q;
	logic [PCOUNT_W-1:0] part_count_q;
	logic                out_valid_q;
	place_rsp_t          out_place_q;

	// Vertex mask memory and its registered read data
	part_mask_t          vmem [VERTEX_COUNT];
	part_mask_t          rd_u_q;
	part_mask_t          rd_v_q;
	logic                rd_en;
	logic                mem_we;
	logic [VADDR_W-1:0]  mem_waddr;
	part_mask_t          mem_wdata;

	// Captured request
	logic [VADDR_W-1:0]  u_q;
	logic [VADDR_W-1:0]  v_q;
	logic [DEGREE_W-1:0] du_q;
	logic [DEGREE_W-1:0] dv_q;

	edge_count_t         cnt_q [MAX_PARTS];
	part_mask_t          act;
	part_mask_t          mu;
	part_mask_t          mv;
	part_mask_t          cand_d;
	logic [1:0]          rule_d;
	part_mask_t          cand_q;
	logic [1:0]          rule_q;
	part_mask_t          win_bit;

	sel_node_t           lvl0 [MAX_PARTS];
	sel_node_t           lvl1 [MAX_PARTS/2];
	sel_node_t           lvl2_d [MAX_PARTS/4];
	sel_node_t           lvl2_s1 [MAX_PARTS/4];
	sel_node_t           lvl3 [MAX_PARTS/8];
	sel_node_t           lvl4_d [MAX_PARTS/16];
	sel_node_t           lvl4_s2 [MAX_PARTS/16];
	sel_node_t           lvl5 [2];
	sel_node_t           best_d;
	sel_node_t           best_s3;

	logic                out_free;

	// Left child always holds the lower indices, so taking the right child on
	// an equal count gives ties to the highest index.
	function automatic sel_node_t pick(input sel_node_t lo, input sel_node_t hi);
		if (hi.ok && (!lo.ok || hi.cnt <= lo.cnt))
			return hi;
		return lo;
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_place = out_place_q;
	assign out_free  = !out_valid_q || out_ready;
	assign rd_en     = in_valid && in_ready;

	// Active partitions: a count of zero still enables partition 0, anything
	// above the maximum enables all.
	always_comb begin
		for (int i = 0; i < MAX_PARTS; i++)
			act[i] = (i == 0) || (PCOUNT_W'(i) < part_count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_count_q <= RESET_PARTS;
		end else if (cfg_we) begin
			part_count_q <= cfg_wdata;
		end
	end

	// Vertex memory: reads only on acceptance, writes only while clearing or
	// writing back, so the two never meet on the same entry.
	always_ff @(posedge clk) begin
		if (mem_we)
			vmem[mem_waddr] <= mem_wdata;
		if (rd_en) begin
			rd_u_q <= vmem[in_data.src_vertex];
			rd_v_q <= vmem[in_data.dst_vertex];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			u_q  <= in_data.src_vertex;
			v_q  <= in_data.dst_vertex;
			du_q <= in_data.src_degree;
			dv_q <= in_data.dst_degree;
		end
	end

	assign win_bit = part_mask_t'(1) << best_s3.idx;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_WU: begin
				mem_we    = 1'b1;
				mem_waddr = u_q;
				mem_wdata = rd_u_q | win_bit;
			end
			ST_WV: begin
				mem_we    = 1'b1;
				mem_waddr = v_q;
				mem_wdata = rd_v_q | win_bit;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Candidate set from the masked endpoint masks
	assign mu = rd_u_q & act;
	assign mv = rd_v_q & act;

	always_comb begin
		priority if (mu == '0 && mv == '0) begin
			cand_d = act;
			rule_d = RULE_BOTH_NEW;
		end else if (mu == '0 || mv == '0) begin
			cand_d = mu | mv;
			rule_d = RULE_ONE_NEW;
		end else if ((mu & mv) != '0) begin
			cand_d = mu & mv;
			rule_d = RULE_OVERLAP;
		end else begin
			// equal degrees fall to the source
			cand_d = (du_q <= dv_q) ? mu : mv;
			rule_d = RULE_FALLBACK;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RULE) begin
			cand_q <= cand_d;
			rule_q <= rule_d;
		end
	end

	// Selection tree, two levels between registers
	always_comb begin
		for (int i = 0; i < MAX_PARTS; i++)
			lvl0[i] = '{ok: cand_q[i], idx: PIDX_W'(i), cnt: cnt_q[i]};
		for (int i = 0; i < MAX_PARTS/2; i++)
			lvl1[i] = pick(lvl0[2*i], lvl0[2*i+1]);
		for (int i = 0; i < MAX_PARTS/4; i++)
			lvl2_d[i] = pick(lvl1[2*i], lvl1[2*i+1]);
	end

	always_comb begin
		for (int i = 0; i < MAX_PARTS/8; i++)
			lvl3[i] = pick(lvl2_s1[2*i], lvl2_s1[2*i+1]);
		for (int i = 0; i < MAX_PARTS/16; i++)
			lvl4_d[i] = pick(lvl3[2*i], lvl3[2*i+1]);
	end

	always_comb begin
		for (int i = 0; i < 2; i++)
			lvl5[i] = pick(lvl4_s2[2*i], lvl4_s2[2*i+1]);
		best_d = pick(lvl5[0], lvl5[1]);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_T1)
			lvl2_s1 <= lvl2_d;
		if (state_q == ST_T2)
			lvl4_s2 <= lvl4_d;
		if (state_q == ST_T3)
			best_s3 <= best_d;
	end

	// Edge counts: bump the winner once, holding at full scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PARTS; i++)
				cnt_q[i] <= '0;
		end else if (state_q == ST_WU && best_s3.cnt != '1) begin
			cnt_q[best_s3.idx] <= best_s3.cnt + COUNT_WIDTH'(1);
		end
	end

	// Sequencer with the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			out_place_q <= '0;
		end else begin
			// drop a collected result unless a new one is loaded this cycle
			if (out_valid_q && out_ready && state_q != ST_WV)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + VADDR_W'(1);
					if (clr_q == '1)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_RULE;
				end
				ST_RULE: state_q <= ST_T1;
				ST_T1:   state_q <= ST_T2;
				ST_T2:   state_q <= ST_T3;
				ST_T3:   state_q <= ST_WU;
				ST_WU:   state_q <= ST_WV;
				ST_WV: begin
					// hold until the result register is free
					if (out_free) begin
						out_valid_q             <= 1'b1;
						out_place_q.chosen_part <= best_s3.idx;
						out_place_q.rule_used   <= rule_q;
						state_q                 <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_accept_to_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_RULE)
		else $error("accepted request did not advance to rule selection");

	a_winner_is_candidate: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WU |-> best_s3.ok && cand_q[best_s3.idx])
		else $error("selected partition is not a candidate");

	a_winner_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WU |-> act[best_s3.idx])
		else $error("selected partition lies outside the active set");

	a_no_read_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && rd_en))
		else $error("vertex memory read and write in the same cycle");

	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WV && out_valid_q && !out_ready |=> state_q == ST_WV)
		else $error("result loaded over an uncollected result");

endmodule

// ===== verif/tb_greedy_vertex_cut_edge_placer_core.sv =====
class placement_scoreboard;
	gvcep_pkg::part_mask_t          vertex_masks [bit [gvcep_pkg::VADDR_W-1:0]];
	gvcep_pkg::edge_count_t         part_loads [gvcep_pkg::MAX_PARTS];
	logic [gvcep_pkg::PCOUNT_W-1:0] parts;
	gvcep_pkg::place_rsp_t          expected_places [$];
	int unsigned                    faults;

	function new();
		foreach (part_loads[i]) part_loads[i] = '0;
		parts  = gvcep_pkg::RESET_PARTS;
		faults = 0;
	endfunction

	function void set_parts(logic [gvcep_pkg::PCOUNT_W-1:0] value);
		parts = value;
	endfunction

	function gvcep_pkg::part_mask_t mask_of(bit [gvcep_pkg::VADDR_W-1:0] vertex);
		if (vertex_masks.exists(vertex)) return vertex_masks[vertex];
		return '0;
	endfunction

	function int unsigned pending();
		return expected_places.size();
	endfunction

	// Place one accepted edge and queue the placement it must produce.
	function void note_edge(gvcep_pkg::edge_req_t e);
		int unsigned           n;
		int unsigned           best;
		bit                    found;
		gvcep_pkg::part_mask_t act;
		gvcep_pkg::part_mask_t mu;
		gvcep_pkg::part_mask_t mv;
		gvcep_pkg::part_mask_t cand;
		gvcep_pkg::place_rsp_t place;

		n = parts;
		if (n < 1) n = 1;
		if (n > gvcep_pkg::MAX_PARTS) n = gvcep_pkg::MAX_PARTS;
		act = (n >= 64) ? '1 : ((gvcep_pkg::part_mask_t'(1) << n) - 1);
		mu = mask_of(e.src_vertex) & act;
		mv = mask_of(e.dst_vertex) & act;

		if (mu == '0 && mv == '0) begin
			cand = act;
			place.rule_used = gvcep_pkg::RULE_BOTH_NEW;
		end else if (mu == '0 || mv == '0) begin
			cand = mu | mv;
			place.rule_used = gvcep_pkg::RULE_ONE_NEW;
		end else if ((mu & mv) != '0) begin
			cand = mu & mv;
			place.rule_used = gvcep_pkg::RULE_OVERLAP;
		end else begin
			cand = (e.src_degree <= e.dst_degree) ? mu : mv;
			place.rule_used = gvcep_pkg::RULE_FALLBACK;
		end

		best  = 0;
		found = 0;
		for (int unsigned i = 0; i < n; i++) begin
			if (cand[i] && (!found || part_loads[i] <= part_loads[best])) begin
				best  = i;
				found = 1;
			end
		end
		place.chosen_part = gvcep_pkg::PIDX_W'(best);

		if (part_loads[best] != '1)
			part_loads[best] = part_loads[best] + gvcep_pkg::edge_count_t'(1);
		vertex_masks[e.src_vertex] = mask_of(e.src_vertex) | (gvcep_pkg::part_mask_t'(1) << best);
		vertex_masks[e.dst_vertex] = mask_of(e.dst_vertex) | (gvcep_pkg::part_mask_t'(1) << best);
		expected_places = {expected_places, place};
	endfunction

	function void check_placement(gvcep_pkg::place_rsp_t got);
		gvcep_pkg::place_rsp_t want;
		if (expected_places.size() == 0) begin
			$display("%0t: unexpected result: part %0d rule %0d", $time,
				got.chosen_part, got.rule_used);
			faults++;
			return;
		end
		want = expected_places.pop_front();
		if (got.chosen_part !== want.chosen_part) begin
			$display("%0t: chosen_part mismatch: expected %0d actual %0d", $time,
				want.chosen_part, got.chosen_part);
			faults++;
		end
		if (got.rule_used !== want.rule_used) begin
			$display("%0t: rule_used mismatch: expected %0d actual %0d", $time,
				want.rule_used, got.rule_used);
			faults++;
		end
	endfunction
endclass

module tb_greedy_vertex_cut_edge_placer_core;
	import gvcep_pkg::*;

	// The clearing sweep writes every one of the VERTEX_COUNT entries; allow the
	// whole run several times over.
	localparam int unsigned CYCLE_LIMIT  = 4 * VERTEX_COUNT + 600_000;
	localparam int          POOL_SIZE    = 40;
	localparam int          PHASE_ITEMS  = 150;
	localparam int          PHASE_COUNT  = 12;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [PCOUNT_W-1:0] cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	edge_req_t           in_data;
	logic                out_valid;
	logic                out_ready = 1'b0;
	place_rsp_t          out_place;

	placement_scoreboard sb;
	int unsigned         cycle_count = 0;
	int unsigned         stall_left  = 0;
	int unsigned         burst_left  = 0;
	logic [VADDR_W-1:0]  vertex_pool [POOL_SIZE];
	logic [PCOUNT_W-1:0] parts_plan [PHASE_COUNT];

	greedy_vertex_cut_edge_placer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_place (out_place)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Receiver back-pressure: cycle through four moods picked by bits 9:8 of the
	// cycle counter -- always ready, coin toss, rare long stalls, and mostly ready.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			case (cycle_count[9:8])
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= 1'($urandom_range(0, 1));
				2'd2: begin
					if ($urandom_range(0, 15) == 0) begin
						out_ready  <= 1'b0;
						stall_left <= $urandom_range(1, 24);
					end else begin
						out_ready <= 1'b1;
					end
				end
				default: out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Compare every collected result against the oldest pending placement.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_placement(out_place);
	end

	function automatic edge_req_t edge_of(logic [VADDR_W-1:0] src, logic [VADDR_W-1:0] dst,
			logic [DEGREE_W-1:0] sdeg, logic [DEGREE_W-1:0] ddeg);
		edge_req_t e;
		e.src_vertex = src;
		e.dst_vertex = dst;
		e.src_degree = sdeg;
		e.dst_degree = ddeg;
		return e;
	endfunction

	// Mostly draw endpoints from a small pool so masks build up and overlap;
	// the rest are fully random ids to exercise every address bit.
	function automatic edge_req_t make_edge();
		edge_req_t   e;
		int unsigned pick;
		e.src_degree = DEGREE_W'($urandom());
		e.dst_degree = DEGREE_W'($urandom());
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			e.src_vertex = VADDR_W'($urandom());
			e.dst_vertex = VADDR_W'($urandom());
		end else begin
			e.src_vertex = vertex_pool[$urandom_range(0, POOL_SIZE - 1)];
			e.dst_vertex = (pick < 20) ? e.src_vertex
				: vertex_pool[$urandom_range(0, POOL_SIZE - 1)];
		end
		case ($urandom_range(0, 9))
			0, 1: e.dst_degree = e.src_degree;
			2: e.src_degree = '0;
			3: e.dst_degree = '1;
			default: ;
		endcase
		return e;
	endfunction

	// Present one request and hold it until the block takes it.
	task automatic send_edge(edge_req_t e);
		in_valid <= 1'b1;
		in_data  <= e;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_edge(e);
	endtask

	// Drop valid and hold off until every placement has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_parts(logic [PCOUNT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_parts(value);
	endtask

	// Random edges in bursts with gaps; every hundred items open with a
	// stretch of back-to-back requests, and the middle of the phase drains.
	task automatic run_phase(int count);
		int unsigned gap;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2) begin
				wait_drained();
				burst_left = 0;
			end
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = ((i % 100) < 25) ? 0 : $urandom_range(0, 6);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			send_edge(make_edge());
			burst_left--;
		end
	endtask

	initial begin
		sb        = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		in_valid  = 1'b0;
		in_data   = '0;

		vertex_pool[0] = '0;
		vertex_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) vertex_pool[i] = VADDR_W'($urandom());
		// Wide counts first, then shrink so stale high bits must be ignored;
		// out-of-range values are clamped to one and to MAX_PARTS.
		parts_plan = '{7'd64, 7'd2, 7'd1, 7'd0, 7'd127, 7'd3, 7'd65, 7'd16,
			7'd33, PCOUNT_W'($urandom_range(1, 64)), 7'd64, 7'd5};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The register may be set while the vertex store is being cleared.
		write_parts(RESET_PARTS);

		// Directed: both new, one new, overlap, fallback on either side and
		// on equal degrees, self loops, extreme ids and degrees.
		send_edge(edge_of('0, '1, '0, '1));
		send_edge(edge_of('0, 20'd5, '1, '0));
		send_edge(edge_of(20'd5, '0, 24'd1, 24'd1));
		send_edge(edge_of(20'd10, 20'd11, '0, '0));
		send_edge(edge_of('0, 20'd10, 24'd100, 24'd200));
		send_edge(edge_of(20'd20, 20'd21, 24'd9, 24'd9));
		send_edge(edge_of(20'd22, 20'd23, 24'd9, 24'd9));
		send_edge(edge_of(20'd20, 20'd22, 24'd300, 24'd100));
		send_edge(edge_of(20'd21, 20'd23, 24'd50, 24'd500));
		send_edge(edge_of(20'd11, 20'd23, 24'd77, 24'd77));
		send_edge(edge_of(20'd30, 20'd30, '1, '1));
		send_edge(edge_of(20'd30, 20'd30, '0, '0));
		send_edge(edge_of('1, '1, 24'h800000, 24'h7FFFFF));
		send_edge(edge_of(20'hAAAAA, 20'h55555, 24'hAAAAAA, 24'h555555));
		send_edge(edge_of(20'h55555, 20'hAAAAA, 24'h555555, 24'hAAAAAA));
		send_edge(edge_of(20'd40, '0, '1, '1));
		wait_drained();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			// Refresh part of the pool so fresh vertices keep turning up.
			for (int k = 0; k < 8; k++)
				vertex_pool[$urandom_range(2, POOL_SIZE - 1)] = VADDR_W'($urandom());
			write_parts(parts_plan[p]);
			run_phase(PHASE_ITEMS);
			wait_drained();
		end

		repeat (16) @(posedge clk);
		if (sb.faults == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/gvcep_pkg.sv
rtl/core/greedy_vertex_cut_edge_placer_core.sv
verif/tb_greedy_vertex_cut_edge_placer_core.sv
